### src/lrmp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrmp_pkg
// Shared types and constants for the linear recurrence term generator.
// ----------------------------------------------------------------------------
package lrmp_pkg;

    localparam int unsigned VAL_BITS = 30;
    localparam logic [VAL_BITS-1:0] MODP = 30'd1000000007;
    localparam int DEF_INDEX_BITS = 63;
    localparam int MAT_DIM = 5;
    localparam int MAT_ENTRIES = 25;
    localparam int ADDR_BITS = 7;

    typedef logic [VAL_BITS-1:0] t_val;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CHECK,
        ST_MUL_RD,
        ST_MUL_WT,
        ST_MUL_ACC,
        ST_COPY,
        ST_SHIFT,
        ST_FIN,
        ST_FIN_WT,
        ST_FIN_ACC,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        BANK_ACC,
        BANK_BASE,
        BANK_TMP
    } t_bank;

endpackage
`default_nettype wire

### src/lrmp_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrmp_ram
// Generic single-port-write, dual-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lrmp_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 64
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr_a,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule
`default_nettype wire

### src/lrmp_mulmod.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrmp_mulmod
// Pipelined modular multiplier: product, Barrett-style reduction, correction.
// One product accepted every cycle.
// ----------------------------------------------------------------------------
module lrmp_mulmod (
    input  wire                    i_clk,
    input  wire lrmp_pkg::t_val    i_x,
    input  wire lrmp_pkg::t_val    i_y,
    output lrmp_pkg::t_val         o_p
);
    import lrmp_pkg::*;

    // The q estimate uses floor(2^60 / P) on the upper 30 bits of the product.
    localparam logic [60:0] MU = 61'd1152921496;

    logic [59:0] r_prod;
    logic [29:0] r_hi;
    logic [59:0] r_prod2;
    logic [60:0] r_q;
    logic [59:0] r_prod3;
    logic [31:0] r_rem;
    logic [59:0] n_qp;
    logic [31:0] n_rem;

    always_ff @(posedge i_clk) begin
        r_prod  <= 60'(i_x) * 60'(i_y);
        r_prod2 <= r_prod;
        r_hi    <= r_prod[59:30];
        r_q     <= 61'(r_hi) * MU;
        r_prod3 <= r_prod2;
        r_rem   <= n_rem;
        o_p     <= (r_rem >= 32'(MODP) * 3) ? VAL_BITS'(r_rem - 32'(MODP) * 3)
                 : (r_rem >= 32'(MODP) * 2) ? VAL_BITS'(r_rem - 32'(MODP) * 2)
                 : (r_rem >= 32'(MODP)) ? VAL_BITS'(r_rem - 32'(MODP))
                 : VAL_BITS'(r_rem);
    end

    always_comb begin
        n_qp  = 60'(r_q[60:30]) * 60'(MODP);
        n_rem = 32'(r_prod3 - n_qp);
    end

endmodule
`default_nettype wire

### src/linear_recurrence_matrix_power_mod.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linear_recurrence_matrix_power_mod
// Term n of a fourth-order linear recurrence modulo 1000000007 by 5x5 matrix
// square-and-multiply over matrices held in one RAM.
// Indices 0 to 4 are answered directly; otherwise the matrices are loaded, and
// each matrix product runs entry by entry on one modular multiplier and is copied
// back, with a squaring per bit of n-4 and a product per set bit, then a final
// dot product with the seed.
// One item at a time; input is accepted again once the result is taken and the
// controller is back in idle. Reset (synchronous, active low) returns the controller to idle.
// ----------------------------------------------------------------------------
module linear_recurrence_matrix_power_mod #(
    parameter int INDEX_BITS = lrmp_pkg::DEF_INDEX_BITS
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_ready,
    input  wire lrmp_pkg::t_val   i_coef_a,
    input  wire lrmp_pkg::t_val   i_coef_b,
    input  wire lrmp_pkg::t_val   i_coef_c,
    input  wire lrmp_pkg::t_val   i_coef_d,
    input  wire lrmp_pkg::t_val   i_coef_e,
    input  wire [62:0]            i_term_index,
    output logic                  o_valid,
    input  wire                   i_ready,
    output lrmp_pkg::t_val        o_term_value,
    output logic                  o_invalid
);
    import lrmp_pkg::*;

    t_state r_state, n_state;
    logic [INDEX_BITS-1:0] r_exp;
    t_val r_coef [MAT_DIM];
    logic [4:0] r_cnt;
    logic [2:0] r_i, r_j, r_k;
    logic r_sq;
    logic [3:0] r_dly;
    t_val r_acc;
    logic r_ovalid;
    t_val r_oval;
    logic r_oinv;
    logic [5:0] r_vld;
    t_val r_fy;
    logic r_ff;

    logic [INDEX_BITS-1:0] w_n;
    logic we;
    logic [ADDR_BITS-1:0] waddr, raddr_a, raddr_b;
    t_val wdata, rd_a, rd_b, prod, mul_x, mul_y, n_accv;
    logic [30:0] sum31;
    logic w_last;
    logic w_fin;
    t_val w_seed_k;

    assign w_n = INDEX_BITS'(i_term_index);

    function automatic logic [ADDR_BITS-1:0] f_addr(t_bank b, logic [2:0] i, logic [2:0] j);
        return ADDR_BITS'(int'(b) * MAT_ENTRIES + int'(i) * MAT_DIM + int'(j));
    endfunction

    function automatic t_val f_red(t_val v);
        return (v >= MODP) ? v - MODP : v;
    endfunction

    lrmp_ram #(.WIDTH(VAL_BITS), .DEPTH(1 << ADDR_BITS)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr_a(raddr_a), .i_raddr_b(raddr_b),
        .o_rdata_a(rd_a), .o_rdata_b(rd_b)
    );

    lrmp_mulmod u_mul (.i_clk(i_clk), .i_x(mul_x), .i_y(mul_y), .o_p(prod));

    assign mul_x = rd_a;
    // Seed operands replace memory port b during the final dot product.
    assign mul_y = r_ff ? r_fy : rd_b;
    assign sum31 = 31'(r_acc) + 31'(prod);
    assign n_accv = (sum31 >= 31'(MODP)) ? VAL_BITS'(sum31 - 31'(MODP)) : VAL_BITS'(sum31);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:    if (i_valid && o_ready) begin
                            if (w_n == '0 || w_n <= INDEX_BITS'(4)) n_state = ST_OUT;
                            else n_state = ST_LOAD;
                        end
            ST_LOAD:    if (r_cnt == 5'(MAT_ENTRIES - 1) && r_sq) n_state = ST_CHECK;
            ST_CHECK:   if (r_exp == '0) n_state = ST_FIN;
                        else n_state = ST_MUL_RD;
            ST_MUL_RD:  if (r_k == 3'(MAT_DIM - 1)) n_state = ST_MUL_WT;
            ST_MUL_WT:  if (r_dly == 4'd5) n_state = ST_MUL_ACC;
            ST_MUL_ACC: if (w_last) n_state = ST_COPY;
                        else n_state = ST_MUL_RD;
            ST_COPY:    if (r_cnt == 5'(MAT_ENTRIES - 1) && r_dly == 4'd1) begin
                            n_state = r_sq ? ST_SHIFT : ST_MUL_RD;
                        end
            ST_SHIFT:   n_state = ST_CHECK;
            ST_FIN:     if (r_k == 3'(MAT_DIM - 1)) n_state = ST_FIN_WT;
            ST_FIN_WT:  if (r_dly == 4'd5) n_state = ST_FIN_ACC;
            ST_FIN_ACC: n_state = ST_OUT;
            ST_OUT:     if (!r_ovalid) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_state == ST_IDLE) && !r_ovalid;
        o_valid = r_ovalid;
        o_term_value = r_oval;
        o_invalid = r_oinv;
        we = 1'b0;
        waddr = '0;
        wdata = '0;
        raddr_a = '0;
        raddr_b = '0;
        case (r_state)
            ST_LOAD: begin
                // Writes identity into acc and the companion matrix into base.
                we = 1'b1;
                waddr = f_addr(BANK_ACC, r_i, r_j);
                wdata = (r_i == r_j) ? VAL_BITS'(1) : '0;
                if (r_sq) begin
                    waddr = f_addr(BANK_BASE, r_i, r_j);
                    if (r_i == 3'd0) wdata = r_coef[r_j];
                    else if (r_i == 3'd4) wdata = (r_j == 3'd4) ? VAL_BITS'(1) : '0;
                    else wdata = (r_j == r_i - 3'd1) ? VAL_BITS'(1) : '0;
                end
            end
            ST_MUL_RD: begin
                raddr_a = f_addr(r_sq ? BANK_BASE : BANK_ACC, r_i, r_k);
                raddr_b = f_addr(BANK_BASE, r_k, r_j);
            end
            ST_MUL_ACC: begin
                we = 1'b1;
                waddr = f_addr(BANK_TMP, r_i, r_j);
                wdata = r_acc;
            end
            ST_COPY: begin
                raddr_a = f_addr(BANK_TMP, r_i, r_j);
                if (r_dly == 4'd1) begin
                    we = 1'b1;
                    waddr = f_addr(r_sq ? BANK_BASE : BANK_ACC, r_i, r_j);
                    wdata = rd_a;
                end
            end
            ST_FIN: begin
                raddr_a = f_addr(BANK_ACC, 3'd0, r_k);
                raddr_b = f_addr(BANK_TMP, 3'd0, 3'd0);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_vld    <= '0;
        end else begin
            r_state <= n_state;
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            r_vld <= {r_vld[4:0], (r_state == ST_MUL_RD) || (r_state == ST_FIN)};
            if (r_state == ST_IDLE && i_valid && o_ready) begin
                r_exp <= w_n - INDEX_BITS'(4);
                r_coef[0] <= f_red(i_coef_a);
                r_coef[1] <= f_red(i_coef_b);
                r_coef[2] <= f_red(i_coef_c);
                r_coef[3] <= f_red(i_coef_d);
                r_coef[4] <= f_red(i_coef_e);
                r_cnt <= '0; r_i <= '0; r_j <= '0; r_k <= '0; r_sq <= 1'b0;
                r_dly <= '0; r_acc <= '0;
                if (w_n == '0) begin
                    r_oval <= '0; r_oinv <= 1'b1; r_ovalid <= 1'b1;
                end else if (w_n <= INDEX_BITS'(4)) begin
                    r_oval <= VAL_BITS'(w_n - INDEX_BITS'(1)); r_oinv <= 1'b0;
                    r_ovalid <= 1'b1;
                end
            end
            case (r_state)
                ST_LOAD: begin
                    if (r_sq) begin
                        r_sq <= 1'b0;
                        r_cnt <= r_cnt + 5'd1;
                        if (r_j == 3'd4) begin r_j <= '0; r_i <= r_i + 3'd1; end
                        else r_j <= r_j + 3'd1;
                    end else r_sq <= 1'b1;
                end
                ST_CHECK: begin
                    r_i <= '0; r_j <= '0; r_k <= '0; r_dly <= '0; r_acc <= '0;
                    r_sq <= !r_exp[0];
                    r_cnt <= '0;
                end
                ST_MUL_RD: begin
                    r_k <= r_k + 3'd1;
                    r_dly <= '0;
                end
                ST_MUL_WT: r_dly <= r_dly + 4'd1;
                ST_MUL_ACC: begin
                    r_acc <= '0; r_k <= '0;
                    if (r_j == 3'd4) begin
                        r_j <= '0;
                        r_i <= w_last ? 3'd0 : r_i + 3'd1;
                    end else r_j <= r_j + 3'd1;
                    r_cnt <= '0; r_dly <= '0;
                end
                ST_COPY: begin
                    if (r_dly == 4'd1) begin
                        r_dly <= '0;
                        if (r_j == 3'd4) begin
                            r_j <= '0;
                            r_i <= w_last ? 3'd0 : r_i + 3'd1;
                        end else r_j <= r_j + 3'd1;
                        if (r_cnt == 5'(MAT_ENTRIES - 1)) begin
                            r_cnt <= '0;
                            r_sq <= 1'b1;
                        end else r_cnt <= r_cnt + 5'd1;
                    end else r_dly <= 4'd1;
                end
                ST_SHIFT: r_exp <= r_exp >> 1;
                ST_FIN: begin r_k <= r_k + 3'd1; r_dly <= '0; end
                ST_FIN_WT: r_dly <= r_dly + 4'd1;
                ST_FIN_ACC: begin
                    r_oval <= r_acc; r_oinv <= 1'b0; r_ovalid <= 1'b1;
                end
                default: ;
            endcase
            if (r_vld[5]) r_acc <= n_accv;
        end
    end

    always_comb w_last = (r_i == 3'd4) && (r_j == 3'd4);
    always_comb w_fin = r_state == ST_FIN;

    // Final dot product needs seed (3,2,1,0,1): feed it through the multiplier.
    always_comb begin
        w_seed_k = '0;
        if (w_fin) begin
            case (r_k)
                3'd0: w_seed_k = VAL_BITS'(3);
                3'd1: w_seed_k = VAL_BITS'(2);
                3'd2: w_seed_k = VAL_BITS'(1);
                3'd4: w_seed_k = VAL_BITS'(1);
                default: w_seed_k = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_fy <= w_seed_k;
        r_ff <= w_fin;
    end

endmodule
`default_nettype wire
